@@ hw/rtl/bole_pkg.sv @@
// shared constants, command and status codes and cell control struct for the list engine
package bole_pkg;

    localparam int DEPTH = 64;
    localparam int VAL_W = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMD_W = 3;
    localparam int ST_W  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND    = 3'd0,
        CMD_INSERT_AT = 3'd1,
        CMD_POP_FRONT = 3'd2,
        CMD_REMOVE_AT = 3'd3,
        CMD_REMOVE_V  = 3'd4,
        CMD_CONTAINS  = 3'd5,
        CMD_READ_AT   = 3'd6,
        CMD_CLEAR     = 3'd7
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic             ins;
        logic             rem_pos;
        logic             rem_match;
        logic             sel_pos;
        logic             sel_match;
        logic [CNT_W-1:0] pos;
        logic [VAL_W-1:0] value;
    } cell_ctrl_t;

endpackage

@@ hw/rtl/bole_cell.sv @@
// one list cell: holds an entry, its match flag and shift/select logic
module bole_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     load_match,
    input  logic [bole_pkg::VAL_W-1:0] cmp_value,
    input  logic [bole_pkg::CNT_W-1:0] count,
    input  logic [bole_pkg::CNT_W-1:0] idx,
    input  bole_pkg::cell_ctrl_t     ctrl,
    input  logic [bole_pkg::VAL_W-1:0] left_data,
    input  logic [bole_pkg::VAL_W-1:0] right_data,
    output logic [bole_pkg::VAL_W-1:0] data_out,
    input  logic                     prior_in,
    output logic                     prior_out,
    input  logic [bole_pkg::VAL_W-1:0] tap_in,
    output logic [bole_pkg::VAL_W-1:0] tap_out
);
    import bole_pkg::*;

    logic [VAL_W-1:0] data_reg;
    logic [VAL_W-1:0] data_next;
    logic             match_reg;
    logic             match_next;
    logic             first_hit;
    logic             ins_here;
    logic             ins_shift;
    logic             rem_here;
    logic             sel;

    // compare against the incoming request value while it is taken
    assign match_next = (data_reg == cmp_value) && (idx < count);

    // first-match priority passes down the chain
    assign prior_out = prior_in | match_reg;
    assign first_hit = match_reg & ~prior_in;

    // shift decisions for this cell
    assign ins_here  = ctrl.ins && (idx == ctrl.pos);
    assign ins_shift = ctrl.ins && (idx > ctrl.pos);
    assign rem_here  = (ctrl.rem_pos && (idx >= ctrl.pos)) || (ctrl.rem_match && prior_out);

    always_comb begin
        if (ins_here) begin
            data_next = ctrl.value;
        end else if (ins_shift) begin
            data_next = left_data;
        end else if (rem_here) begin
            data_next = right_data;
        end else begin
            data_next = data_reg;
        end
    end

    // selected entry is or-ed onto the read tap
    assign sel     = (ctrl.sel_pos && (idx == ctrl.pos)) || (ctrl.sel_match && first_hit);
    assign tap_out = tap_in | (sel ? data_reg : '0);
    assign data_out = data_reg;

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else if (load_match) begin
            match_reg <= match_next;
        end
    end

endmodule

@@ hw/rtl/bole_chain.sv @@
// row of list cells with neighbour, priority and read-tap links
module bole_chain (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     load_match,
    input  logic [bole_pkg::VAL_W-1:0] cmp_value,
    input  logic [bole_pkg::CNT_W-1:0] count,
    input  bole_pkg::cell_ctrl_t     ctrl,
    output logic                     any_match,
    output logic [bole_pkg::VAL_W-1:0] tap_data
);
    import bole_pkg::*;

    logic [VAL_W-1:0] data_w  [DEPTH];
    logic [VAL_W-1:0] left_w  [DEPTH];
    logic [VAL_W-1:0] right_w [DEPTH];
    logic [VAL_W-1:0] tap_w   [DEPTH+1];
    logic             prior_w [DEPTH+1];

    assign tap_w[0]   = '0;
    assign prior_w[0] = 1'b0;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            // ends of the row feed back their own entry
            if (i == 0) begin : g_first
                assign left_w[i] = data_w[i];
            end else begin : g_mid_l
                assign left_w[i] = data_w[i-1];
            end
            if (i == DEPTH - 1) begin : g_last
                assign right_w[i] = data_w[i];
            end else begin : g_mid_r
                assign right_w[i] = data_w[i+1];
            end

            bole_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .load_match (load_match),
                .cmp_value  (cmp_value),
                .count      (count),
                .idx        (CNT_W'(i)),
                .ctrl       (ctrl),
                .left_data  (left_w[i]),
                .right_data (right_w[i]),
                .data_out   (data_w[i]),
                .prior_in   (prior_w[i]),
                .prior_out  (prior_w[i+1]),
                .tap_in     (tap_w[i]),
                .tap_out    (tap_w[i+1])
            );
        end
    endgenerate

    assign any_match = prior_w[DEPTH];
    assign tap_data  = tap_w[DEPTH];

endmodule

@@ hw/rtl/bounded_ordered_list_engine.sv @@
// top level: request sequencer, length counter and result register around the cell chain
//
//  channel  | ports                                         | direction
//  request  | s_valid s_ready s_cmd s_value s_position      | in
//  result   | m_valid m_ready m_status m_value_out m_found  | out
//           | m_length_out                                  |
//
// Accepting a request captures it and loads the compare flag of every cell;
// the execute edge then resolves the first-match chain, shifts the cells and
// registers the result. A new request is taken once the result register
// holds the previous result; a stalled result holds the engine in its execute
// state. Reset clears the length and control state; cell entries are not
// cleared, since only entries below the length are ever read.
module bounded_ordered_list_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [31:0] s_value,
    input  logic [6:0]  s_position,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_value_out,
    output logic        m_found,
    output logic [6:0]  m_length_out
);
    import bole_pkg::*;

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    state_t           state_reg;
    cmd_t             cmd_reg;
    logic [VAL_W-1:0] val_reg;
    logic [CNT_W-1:0] pos_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    status_t          status_reg;
    status_t          status_next;
    logic [VAL_W-1:0] vout_reg;
    logic             found_reg;
    logic             found_next;

    logic             accept;
    logic             exec_go;
    logic             any_match;
    logic [VAL_W-1:0] tap_data;
    cell_ctrl_t       ctrl;
    logic             act_ins;
    logic             act_rem_pos;
    logic             act_rem_match;
    logic             act_sel_pos;
    logic             act_sel_match;
    logic [CNT_W-1:0] eff_pos;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign exec_go = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);

    // command decode and status
    always_comb begin
        act_ins       = 1'b0;
        act_rem_pos   = 1'b0;
        act_rem_match = 1'b0;
        act_sel_pos   = 1'b0;
        act_sel_match = 1'b0;
        status_next   = ST_OK;
        found_next    = 1'b0;
        count_next    = count_reg;
        eff_pos       = pos_reg;
        case (cmd_reg)
            CMD_APPEND: begin
                eff_pos = count_reg;
                if (count_reg >= CNT_W'(DEPTH)) begin
                    status_next = ST_FULL;
                end else begin
                    act_ins    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_INSERT_AT: begin
                if (pos_reg > count_reg) begin
                    status_next = ST_BADPOS;
                end else if (count_reg >= CNT_W'(DEPTH)) begin
                    status_next = ST_FULL;
                end else begin
                    act_ins    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_POP_FRONT: begin
                eff_pos = '0;
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else begin
                    act_rem_pos = 1'b1;
                    act_sel_pos = 1'b1;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            CMD_REMOVE_AT: begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else if (pos_reg >= count_reg) begin
                    status_next = ST_BADPOS;
                end else begin
                    act_rem_pos = 1'b1;
                    act_sel_pos = 1'b1;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            CMD_REMOVE_V: begin
                if (any_match) begin
                    found_next    = 1'b1;
                    act_rem_match = 1'b1;
                    act_sel_match = 1'b1;
                    count_next    = count_reg - CNT_W'(1);
                end else begin
                    status_next = ST_NOTFOUND;
                end
            end
            CMD_CONTAINS: begin
                if (any_match) begin
                    found_next = 1'b1;
                end else begin
                    status_next = ST_NOTFOUND;
                end
            end
            CMD_READ_AT: begin
                if (pos_reg >= count_reg) begin
                    status_next = ST_BADPOS;
                end else begin
                    act_sel_pos = 1'b1;
                end
            end
            CMD_CLEAR: begin
                count_next = '0;
            end
            default: begin
                status_next = ST_OK;
            end
        endcase
    end

    // cell control only moves entries on the execute edge
    always_comb begin
        ctrl.ins       = act_ins && exec_go;
        ctrl.rem_pos   = act_rem_pos && exec_go;
        ctrl.rem_match = act_rem_match && exec_go;
        ctrl.sel_pos   = act_sel_pos;
        ctrl.sel_match = act_sel_match;
        ctrl.pos       = eff_pos;
        ctrl.value     = val_reg;
    end

    bole_chain u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_match (accept),
        .cmp_value  (s_value[VAL_W-1:0]),
        .count      (count_reg),
        .ctrl       (ctrl),
        .any_match  (any_match),
        .tap_data   (tap_data)
    );

    // request capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= cmd_t'(s_cmd);
            val_reg <= s_value[VAL_W-1:0];
            pos_reg <= s_position[CNT_W-1:0];
        end
    end

    // sequencer, length and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (m_valid_reg && m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                    if (accept) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_go) begin
                        state_reg   <= S_IDLE;
                        count_reg   <= count_next;
                        m_valid_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_go) begin
            status_reg <= status_next;
            vout_reg   <= tap_data;
            found_reg  <= found_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_value_out  = vout_reg;
    assign m_found      = found_reg;
    assign m_length_out = count_reg;

endmodule

@@ tb/sv/tb_bounded_ordered_list_engine.sv @@
// self-checking testbench for the bounded ordered list engine
`timescale 1ns / 100ps

module tb_bounded_ordered_list_engine;

    import bole_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 1150;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;

    // expected reply of one request
    typedef struct packed {
        status_t     status;
        logic [31:0] value;
        logic        found;
        logic [6:0]  len;
    } list_reply_t;

    typedef enum int {
        SINK_STEADY,
        SINK_COIN,
        SINK_SPARSE
    } sink_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_cmd;
    logic [31:0] s_value;
    logic [6:0]  s_position;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [31:0] m_value_out;
    logic        m_found;
    logic [6:0]  m_length_out;

    // shadow copy of the list
    logic [VAL_W-1:0] shadow_list [DEPTH];
    int               shadow_len;

    list_reply_t list_replies_due [$];
    int          err_count;
    int          burst_left;

    bounded_ordered_list_engine uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_value      (s_value),
        .s_position   (s_position),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_value_out  (m_value_out),
        .m_found      (m_found),
        .m_length_out (m_length_out)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // close the gap left by a removed entry
    function automatic void shadow_drop(input int at);
        for (int i = at; i + 1 < shadow_len; i++) begin
            shadow_list[i] = shadow_list[i + 1];
        end
        shadow_len--;
    endfunction

    // apply one request to the shadow list and work out its reply
    function automatic list_reply_t exec_list_cmd(input cmd_t c, input logic [31:0] v,
                                                  input logic [6:0] p);
        list_reply_t r;
        int          pos;
        int          hit;
        pos      = int'(p);
        hit      = -1;
        r.status = ST_OK;
        r.value  = '0;
        r.found  = 1'b0;
        case (c)
            CMD_APPEND: begin
                if (shadow_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    shadow_list[shadow_len] = v;
                    shadow_len++;
                end
            end
            CMD_INSERT_AT: begin
                // past the tail is checked before fullness
                if (pos > shadow_len) begin
                    r.status = ST_BADPOS;
                end else if (shadow_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = shadow_len; i > pos; i--) begin
                        shadow_list[i] = shadow_list[i - 1];
                    end
                    shadow_list[pos] = v;
                    shadow_len++;
                end
            end
            CMD_POP_FRONT: begin
                if (shadow_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.value = shadow_list[0];
                    shadow_drop(0);
                end
            end
            CMD_REMOVE_AT: begin
                if (shadow_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (pos >= shadow_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    r.value = shadow_list[pos];
                    shadow_drop(pos);
                end
            end
            CMD_REMOVE_V, CMD_CONTAINS: begin
                // first match from the front wins
                r.status = ST_NOTFOUND;
                for (int i = 0; i < shadow_len; i++) begin
                    if (hit < 0 && shadow_list[i] == v) hit = i;
                end
                if (hit >= 0) begin
                    r.status = ST_OK;
                    r.found  = 1'b1;
                    if (c == CMD_REMOVE_V) begin
                        r.value = shadow_list[hit];
                        shadow_drop(hit);
                    end
                end
            end
            CMD_READ_AT: begin
                if (pos >= shadow_len) r.status = ST_BADPOS;
                else r.value = shadow_list[pos];
            end
            default: begin
                shadow_len = 0;
            end
        endcase
        r.len = shadow_len[6:0];
        return r;
    endfunction

    // send one request, called and left at a falling edge
    task automatic issue_request(input cmd_t c, input logic [31:0] v, input logic [6:0] p);
        int gap;
        int roll;
        bit taken;
        taken = 1'b0;
        // burst and gap pattern of the sender
        if (burst_left == 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) gap = $urandom_range(1, 3);
            else if (roll < 90) gap = $urandom_range(4, 12);
            else gap = $urandom_range(13, 24);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid    = 1'b1;
        s_cmd      = c;
        s_value    = v;
        s_position = p;
        while (!taken) begin
            @(posedge aclk);
            if (s_ready) begin
                taken = 1'b1;
                list_replies_due.push_back(exec_list_cmd(c, v, p));
            end
            @(negedge aclk);
        end
    endtask

    // hold the sender off until every reply has come back
    task automatic wait_drained();
        s_valid = 1'b0;
        while (list_replies_due.size() != 0) @(negedge aclk);
        burst_left = 0;
    endtask

    // small pool so that duplicates and matches are common
    function automatic logic [31:0] pool_value();
        case ($urandom_range(0, 11))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h8000_0000;
            5:       return 32'h0000_0005;
            6:       return 32'h0000_0007;
            7:       return 32'h0000_002A;
            8:       return 32'hFFFF_FFD6;
            9:       return 32'h0000_0064;
            10:      return 32'h5555_5555;
            default: return 32'hAAAA_AAAA;
        endcase
    endfunction

    function automatic logic [31:0] pick_value(input cmd_t c);
        int roll;
        roll = $urandom_range(0, 99);
        if ((c == CMD_REMOVE_V || c == CMD_CONTAINS) && shadow_len > 0 && roll < 60)
            return shadow_list[$urandom_range(0, shadow_len - 1)];
        if (roll < 80) return pool_value();
        return $urandom;
    endfunction

    function automatic logic [6:0] pick_position(input cmd_t c);
        int roll;
        int top;
        roll = $urandom_range(0, 99);
        top  = (c == CMD_INSERT_AT) ? shadow_len : shadow_len - 1;
        if (top < 0) top = 0;
        if (roll < 85) return 7'($urandom_range(0, top));
        if (roll < 93) return 7'(shadow_len + $urandom_range(0, 1));
        return 7'($urandom_range(0, 127));
    endfunction

    // empty list cases, extremes of value and position, every command
    task automatic test_corner_cases();
        issue_request(CMD_POP_FRONT, 32'h0, 7'd0);
        issue_request(CMD_REMOVE_AT, 32'h0, 7'd0);
        issue_request(CMD_REMOVE_V, 32'h0, 7'd0);
        issue_request(CMD_CONTAINS, 32'h0, 7'd0);
        issue_request(CMD_READ_AT, 32'h0, 7'd0);
        issue_request(CMD_INSERT_AT, 32'h1234_5678, 7'd1);
        issue_request(CMD_INSERT_AT, 32'h7FFF_FFFF, 7'd0);
        issue_request(CMD_APPEND, 32'h8000_0000, 7'd0);
        issue_request(CMD_APPEND, 32'hFFFF_FFFF, 7'd127);
        issue_request(CMD_INSERT_AT, 32'h0000_0000, 7'd3);
        issue_request(CMD_INSERT_AT, 32'h5555_5555, 7'd1);
        issue_request(CMD_READ_AT, 32'hFFFF_FFFF, 7'd0);
        issue_request(CMD_READ_AT, 32'h0, 7'd4);
        issue_request(CMD_READ_AT, 32'h0, 7'd5);
        issue_request(CMD_READ_AT, 32'h0, 7'd127);
        issue_request(CMD_CONTAINS, 32'hFFFF_FFFF, 7'd0);
        issue_request(CMD_CONTAINS, 32'h0000_3039, 7'd0);
        issue_request(CMD_APPEND, 32'hFFFF_FFFF, 7'd0);
        issue_request(CMD_REMOVE_V, 32'hFFFF_FFFF, 7'd0);
        issue_request(CMD_REMOVE_V, 32'h0000_0063, 7'd0);
        issue_request(CMD_REMOVE_AT, 32'h0, 7'd64);
        issue_request(CMD_REMOVE_AT, 32'hAAAA_AAAA, 7'd2);
        issue_request(CMD_POP_FRONT, 32'h0, 7'd0);
        issue_request(CMD_CLEAR, 32'hAAAA_AAAA, 7'd85);
        issue_request(CMD_POP_FRONT, 32'h0, 7'd0);
    endtask

    // fill to the limit, then push against it
    task automatic test_full_list();
        cmd_t c;
        issue_request(CMD_CLEAR, 32'h0, 7'd0);
        while (shadow_len < DEPTH) begin
            c = ($urandom_range(0, 1) == 0) ? CMD_APPEND : CMD_INSERT_AT;
            issue_request(c, $urandom, 7'($urandom_range(0, shadow_len)));
        end
        issue_request(CMD_APPEND, 32'h0000_0001, 7'd0);
        issue_request(CMD_INSERT_AT, 32'h0000_0001, 7'd64);
        issue_request(CMD_INSERT_AT, 32'h0000_0001, 7'd0);
        issue_request(CMD_INSERT_AT, 32'h0000_0001, 7'd65);
        issue_request(CMD_INSERT_AT, 32'h0000_0001, 7'd127);
        issue_request(CMD_CONTAINS, shadow_list[DEPTH - 1], 7'd0);
        issue_request(CMD_READ_AT, 32'h0, 7'd63);
        issue_request(CMD_READ_AT, 32'h0, 7'd64);
        issue_request(CMD_REMOVE_AT, 32'h0, 7'd64);
        issue_request(CMD_REMOVE_AT, 32'h0, 7'd63);
        issue_request(CMD_INSERT_AT, 32'h8000_0000, 7'd63);
        issue_request(CMD_REMOVE_V, shadow_list[31], 7'd0);
        issue_request(CMD_POP_FRONT, 32'h0, 7'd0);
        issue_request(CMD_CLEAR, 32'h0, 7'd0);
    endtask

    // random command mix drifting between fill levels
    task automatic test_random_traffic();
        int   fill_goal;
        int   roll;
        cmd_t c;
        fill_goal = 16;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 4))
                    0:       fill_goal = 2;
                    1:       fill_goal = 16;
                    2:       fill_goal = 40;
                    3:       fill_goal = 60;
                    default: fill_goal = DEPTH;
                endcase
            end
            if (n == RANDOM_ITEMS / 2) wait_drained();
            if ($urandom_range(0, 99) < 3) begin
                // noise: any command with any operands
                issue_request(cmd_t'($urandom_range(0, 7)), $urandom,
                              7'($urandom_range(0, 127)));
            end else begin
                roll = $urandom_range(0, 99);
                if (shadow_len < fill_goal) begin
                    if (roll < 35) c = CMD_APPEND;
                    else if (roll < 65) c = CMD_INSERT_AT;
                    else if (roll < 75) c = CMD_CONTAINS;
                    else if (roll < 85) c = CMD_READ_AT;
                    else if (roll < 92) c = CMD_REMOVE_V;
                    else if (roll < 97) c = CMD_REMOVE_AT;
                    else c = CMD_POP_FRONT;
                end else begin
                    if (roll < 20) c = CMD_POP_FRONT;
                    else if (roll < 45) c = CMD_REMOVE_AT;
                    else if (roll < 65) c = CMD_REMOVE_V;
                    else if (roll < 75) c = CMD_CONTAINS;
                    else if (roll < 85) c = CMD_READ_AT;
                    else if (roll < 93) c = CMD_APPEND;
                    else if (roll < 99) c = CMD_INSERT_AT;
                    else c = CMD_CLEAR;
                end
                issue_request(c, pick_value(c), pick_position(c));
            end
        end
    endtask

    // receiver stall pattern
    initial begin : sink_pattern
        sink_mode_t mode;
        int         mode_left;
        int         sparse_gap;
        int         phase;
        mode       = SINK_STEADY;
        mode_left  = 0;
        sparse_gap = 2;
        phase      = 0;
        forever begin
            @(negedge aclk);
            if (mode_left == 0) begin
                mode       = sink_mode_t'($urandom_range(0, 2));
                mode_left  = $urandom_range(32, 256);
                sparse_gap = $urandom_range(2, 8);
            end
            mode_left--;
            case (mode)
                SINK_STEADY: m_ready = 1'b1;
                SINK_COIN:   m_ready = 1'($urandom_range(0, 1));
                default: begin
                    phase++;
                    m_ready = (phase % sparse_gap == 0);
                end
            endcase
        end
    end

    // compare each reply with the oldest expectation
    always @(posedge aclk) begin : check_replies
        list_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (list_replies_due.size() == 0) begin
                $display("%0t: reply with none expected: status %0d value %h found %0b len %0d",
                         $time, m_status, m_value_out, m_found, m_length_out);
                err_count++;
            end else begin
                want = list_replies_due.pop_front();
                if (m_status != want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_status);
                    err_count++;
                end
                if (m_value_out != want.value) begin
                    $display("%0t: value_out expected %h actual %h",
                             $time, want.value, m_value_out);
                    err_count++;
                end
                if (m_found != want.found) begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, want.found, m_found);
                    err_count++;
                end
                if (m_length_out != want.len) begin
                    $display("%0t: length_out expected %0d actual %0d",
                             $time, want.len, m_length_out);
                    err_count++;
                end
            end
        end
    end

    // end the run when no request or reply moves for too long
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle = 0;
            else idle++;
        end
        $display("tb_bounded_ordered_list_engine failed");
        $finish;
    end

    // main sequence
    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_cmd      = CMD_APPEND;
        s_value    = '0;
        s_position = '0;
        m_ready    = 1'b0;
        err_count  = 0;
        burst_left = 0;
        shadow_len = 0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_corner_cases();
        test_full_list();
        test_random_traffic();

        // drain and let the engine settle
        s_valid = 1'b0;
        while (list_replies_due.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb_bounded_ordered_list_engine passed");
        end else begin
            $display("tb_bounded_ordered_list_engine failed");
        end
        $finish;
    end

endmodule
